[design/rar_pkg.sv]
// Shared types, constants and codes for the rational arithmetic reduce unit.
package rar_pkg;

  localparam int OPERAND_WIDTH_DEF = 16;
  localparam int REQ_W             = 2;
  localparam int NUM_W             = 33;
  localparam int DEN_W             = 31;
  localparam int STATUS_W          = 2;
  localparam int EXT_W             = 64;

  typedef enum logic [REQ_W-1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_DIV_ZERO = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_SIGN,
    S_GCD,
    S_DINIT,
    S_DIV,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    MS_P0,
    MS_P1,
    MS_P2
  } mstep_t;

  typedef struct packed {
    logic   idle;
    logic   mul_en;
    mstep_t mstep;
    logic   n_load;
    logic   n_acc;
    logic   m_load;
    logic   sign_load;
    logic   gcd_step;
    logic   div_init;
    logic   div_step;
    logic   out_load;
  } cmd_t;

  typedef struct packed {
    logic err;
    logic n_zero;
    logic gcd_done;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

[design/rar_if.sv]
// Valid/ready channel interfaces for operand and result transactions.
interface rar_in_if #(
  parameter int OPERAND_WIDTH = rar_pkg::OPERAND_WIDTH_DEF
);
  logic                            valid;
  logic                            ready;
  logic [rar_pkg::REQ_W-1:0]       req_type;
  logic signed [OPERAND_WIDTH-1:0] num_a;
  logic signed [OPERAND_WIDTH-1:0] den_a;
  logic signed [OPERAND_WIDTH-1:0] num_b;
  logic signed [OPERAND_WIDTH-1:0] den_b;

  modport source (output valid, output req_type, output num_a, output den_a,
                  output num_b, output den_b, input ready);
  modport sink   (input valid, input req_type, input num_a, input den_a,
                  input num_b, input den_b, output ready);
endinterface

interface rar_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [rar_pkg::NUM_W-1:0] result_num;
  logic [rar_pkg::DEN_W-1:0]        result_den;
  logic [rar_pkg::STATUS_W-1:0]     status;

  modport source (output valid, output result_num, output result_den,
                  output status, input ready);
  modport sink   (input valid, input result_num, input result_den,
                  input status, output ready);
endinterface

[design/rar_ctrl.sv]
// Sequencing state machine for the rational arithmetic reduce unit.
module rar_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  rar_pkg::sts_t sts,
  output rar_pkg::cmd_t cmd
);

  rar_pkg::state_t state_r;
  rar_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rar_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rar_pkg::S_IDLE:  if (in_valid) state_nxt = rar_pkg::S_MUL0;
      rar_pkg::S_MUL0:  state_nxt = sts.err ? rar_pkg::S_OUT : rar_pkg::S_MUL1;
      rar_pkg::S_MUL1:  state_nxt = rar_pkg::S_MUL2;
      rar_pkg::S_MUL2:  state_nxt = rar_pkg::S_MUL3;
      rar_pkg::S_MUL3:  state_nxt = rar_pkg::S_SIGN;
      rar_pkg::S_SIGN:  state_nxt = sts.n_zero ? rar_pkg::S_OUT : rar_pkg::S_GCD;
      rar_pkg::S_GCD:   if (sts.gcd_done) state_nxt = rar_pkg::S_DINIT;
      rar_pkg::S_DINIT: state_nxt = rar_pkg::S_DIV;
      rar_pkg::S_DIV:   if (sts.div_done) state_nxt = rar_pkg::S_OUT;
      rar_pkg::S_OUT:   if (sts.out_free) state_nxt = rar_pkg::S_IDLE;
      default:          state_nxt = rar_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.mstep = rar_pkg::MS_P0;
    unique case (state_r)
      rar_pkg::S_IDLE:  cmd.idle = 1'b1;
      rar_pkg::S_MUL0: begin
        cmd.mul_en = 1'b1;
        cmd.mstep  = rar_pkg::MS_P0;
      end
      rar_pkg::S_MUL1: begin
        cmd.mul_en = 1'b1;
        cmd.mstep  = rar_pkg::MS_P1;
        cmd.n_load = 1'b1;
      end
      rar_pkg::S_MUL2: begin
        cmd.mul_en = 1'b1;
        cmd.mstep  = rar_pkg::MS_P2;
        cmd.n_acc  = 1'b1;
      end
      rar_pkg::S_MUL3:  cmd.m_load    = 1'b1;
      rar_pkg::S_SIGN:  cmd.sign_load = 1'b1;
      rar_pkg::S_GCD:   cmd.gcd_step  = 1'b1;
      rar_pkg::S_DINIT: cmd.div_init  = 1'b1;
      rar_pkg::S_DIV:   cmd.div_step  = 1'b1;
      rar_pkg::S_OUT:   cmd.out_load  = sts.out_free;
      default:          cmd.idle      = 1'b0;
    endcase
  end

endmodule

[design/rar_datapath.sv]
// Multiplier, binary gcd, dual restoring divider and result register.
module rar_datapath #(
  parameter int OPERAND_WIDTH = rar_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  rar_pkg::cmd_t                    cmd,
  output rar_pkg::sts_t                    sts,
  input  logic                             in_valid,
  input  logic [rar_pkg::REQ_W-1:0]        in_req_type,
  input  logic signed [OPERAND_WIDTH-1:0]  in_num_a,
  input  logic signed [OPERAND_WIDTH-1:0]  in_den_a,
  input  logic signed [OPERAND_WIDTH-1:0]  in_num_b,
  input  logic signed [OPERAND_WIDTH-1:0]  in_den_b,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [rar_pkg::NUM_W-1:0] out_result_num,
  output logic [rar_pkg::DEN_W-1:0]        out_result_den,
  output logic [rar_pkg::STATUS_W-1:0]     out_status
);

  localparam int W  = OPERAND_WIDTH;
  localparam int MW = 2 * OPERAND_WIDTH;
  localparam int PW = MW + 1;
  localparam int KW = $clog2(MW);
  localparam logic [KW-1:0] CNT_LAST = KW'(MW - 1);

  rar_pkg::op_t       op_r;
  rar_pkg::status_t   stat_r;
  rar_pkg::status_t   stat_nxt;
  logic signed [W-1:0] a_r, b_r, c_r, d_r;

  logic signed [W-1:0]  mul_x, mul_y;
  logic signed [MW-1:0] mul_p;
  logic signed [MW-1:0] prod_r;
  logic signed [PW-1:0] prod_ext;
  logic signed [PW-1:0] n_r;
  logic signed [MW-1:0] m_r;
  logic signed [PW-1:0] n_neg;
  logic signed [MW-1:0] m_neg;
  logic [MW-1:0]        n_mag, m_mag;

  logic          neg_r, zero_r;
  logic [MW-1:0] x_r, y_r, un_r, um_r;
  logic [KW-1:0] k_r;
  logic [MW-1:0] dxy, dyx;

  logic [MW-1:0] g_r, dn_r, dm_r, rn_r, rm_r;
  logic [KW-1:0] cnt_r;
  logic [MW:0]   tn, tm, sn, sm;
  logic          ge_n, ge_m;

  logic [rar_pkg::EXT_W-1:0] mag64, num64, den64;
  logic                      in_load;

  logic                             out_valid_r;
  logic signed [rar_pkg::NUM_W-1:0] num_out_r;
  logic [rar_pkg::DEN_W-1:0]        den_out_r;
  logic [rar_pkg::STATUS_W-1:0]     stat_out_r;

  assign in_load = cmd.idle && in_valid;

  always_comb begin
    if (in_den_a == '0 || in_den_b == '0) begin
      stat_nxt = rar_pkg::ST_ZERO_DEN;
    end else if (rar_pkg::op_t'(in_req_type) == rar_pkg::OP_DIV && in_num_b == '0) begin
      stat_nxt = rar_pkg::ST_DIV_ZERO;
    end else begin
      stat_nxt = rar_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      op_r   <= rar_pkg::op_t'(in_req_type);
      stat_r <= stat_nxt;
      a_r    <= in_num_a;
      b_r    <= in_den_a;
      c_r    <= in_num_b;
      d_r    <= in_den_b;
    end
  end

  always_comb begin
    unique case (cmd.mstep)
      rar_pkg::MS_P0: begin
        mul_x = a_r;
        mul_y = (op_r == rar_pkg::OP_MUL) ? c_r : d_r;
      end
      rar_pkg::MS_P1: begin
        mul_x = b_r;
        mul_y = c_r;
      end
      rar_pkg::MS_P2: begin
        mul_x = b_r;
        mul_y = (op_r == rar_pkg::OP_DIV) ? c_r : d_r;
      end
      default: begin
        mul_x = a_r;
        mul_y = d_r;
      end
    endcase
  end

  assign mul_p    = mul_x * mul_y;
  assign prod_ext = {prod_r[MW-1], prod_r};
  assign n_neg    = -n_r;
  assign m_neg    = -m_r;
  assign n_mag    = n_r[PW-1] ? n_neg[MW-1:0] : n_r[MW-1:0];
  assign m_mag    = m_r[MW-1] ? m_neg : m_r;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= mul_p;
    end
    if (cmd.n_load) begin
      n_r <= prod_ext;
    end else if (cmd.n_acc) begin
      case (op_r)
        rar_pkg::OP_ADD: n_r <= n_r + prod_ext;
        rar_pkg::OP_SUB: n_r <= n_r - prod_ext;
        default:         n_r <= n_r;
      endcase
    end
    if (cmd.m_load) begin
      m_r <= prod_r;
    end
  end

  // binary gcd: one halving or odd difference step per cycle
  assign dxy = x_r - y_r;
  assign dyx = y_r - x_r;

  always_ff @(posedge clk) begin
    if (in_load) begin
      zero_r <= 1'b0;
    end else if (cmd.sign_load) begin
      zero_r <= (n_r == '0);
      neg_r  <= n_r[PW-1] ^ m_r[MW-1];
      x_r    <= n_mag;
      y_r    <= m_mag;
      un_r   <= n_mag;
      um_r   <= m_mag;
      k_r    <= '0;
    end else if (cmd.gcd_step && x_r != y_r) begin
      if (!x_r[0] && !y_r[0]) begin
        x_r <= x_r >> 1;
        y_r <= y_r >> 1;
        k_r <= k_r + KW'(1);
      end else if (!x_r[0]) begin
        x_r <= x_r >> 1;
      end else if (!y_r[0]) begin
        y_r <= y_r >> 1;
      end else if (x_r > y_r) begin
        x_r <= dxy >> 1;
      end else begin
        y_r <= dyx >> 1;
      end
    end
  end

  // restoring division of both magnitudes by the gcd, one quotient bit per cycle
  assign tn   = {rn_r, dn_r[MW-1]};
  assign tm   = {rm_r, dm_r[MW-1]};
  assign ge_n = tn >= {1'b0, g_r};
  assign ge_m = tm >= {1'b0, g_r};
  assign sn   = tn - {1'b0, g_r};
  assign sm   = tm - {1'b0, g_r};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      g_r   <= x_r << k_r;
      dn_r  <= un_r;
      dm_r  <= um_r;
      rn_r  <= '0;
      rm_r  <= '0;
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      rn_r  <= ge_n ? sn[MW-1:0] : tn[MW-1:0];
      rm_r  <= ge_m ? sm[MW-1:0] : tm[MW-1:0];
      dn_r  <= {dn_r[MW-2:0], ge_n};
      dm_r  <= {dm_r[MW-2:0], ge_m};
      cnt_r <= cnt_r + KW'(1);
    end
  end

  assign mag64 = {{(rar_pkg::EXT_W - MW){1'b0}}, dn_r};
  assign num64 = neg_r ? (rar_pkg::EXT_W'(0) - mag64) : mag64;
  assign den64 = {{(rar_pkg::EXT_W - MW){1'b0}}, dm_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      stat_out_r <= stat_r;
      if (stat_r != rar_pkg::ST_OK) begin
        num_out_r <= '0;
        den_out_r <= '0;
      end else if (zero_r) begin
        num_out_r <= '0;
        den_out_r <= rar_pkg::DEN_W'(1);
      end else begin
        num_out_r <= num64[rar_pkg::NUM_W-1:0];
        den_out_r <= den64[rar_pkg::DEN_W-1:0];
      end
    end
  end

  assign sts.err      = (stat_r != rar_pkg::ST_OK);
  assign sts.n_zero   = (n_r == '0);
  assign sts.gcd_done = (x_r == y_r);
  assign sts.div_done = (cnt_r == CNT_LAST);
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid      = out_valid_r;
  assign out_result_num = num_out_r;
  assign out_result_den = den_out_r;
  assign out_status     = stat_out_r;

endmodule

[design/rational_arith_reduce_unit.sv]
// Top level of the rational arithmetic reduce unit: controller, datapath and channels.
//
//   channel    dir   handshake       payload
//   in_chan    in    valid/ready     req_type, num_a, den_a, num_b, den_b
//   out_chan   out   valid/ready     result_num, result_den, status
//
// One transaction at a time. A transaction passes through the multiply states,
// the sign state, the data-dependent binary gcd loop, the divider init state,
// the divider loop and the output state, and the unit returns to idle before
// the next accept. Error results go to the output state straight from the first
// multiply state, zero results straight from the sign state.
// Reset is synchronous on rst_n. A waiting result holds out_chan while
// in_chan accepts; the next result waits in the output cycle until it is free.
module rational_arith_reduce_unit #(
  parameter int OPERAND_WIDTH = rar_pkg::OPERAND_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  rar_in_if.sink    in_chan,
  rar_out_if.source out_chan
);

  rar_pkg::cmd_t cmd;
  rar_pkg::sts_t sts;

  assign in_chan.ready = cmd.idle;

  rar_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .sts      (sts),
    .cmd      (cmd)
  );

  rar_datapath #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_valid       (in_chan.valid),
    .in_req_type    (in_chan.req_type),
    .in_num_a       (in_chan.num_a),
    .in_den_a       (in_chan.den_a),
    .in_num_b       (in_chan.num_b),
    .in_den_b       (in_chan.den_b),
    .out_valid      (out_chan.valid),
    .out_ready      (out_chan.ready),
    .out_result_num (out_chan.result_num),
    .out_result_den (out_chan.result_den),
    .out_status     (out_chan.status)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready |=> !in_chan.ready)
    else $error("input taken while a transaction is in flight");

  a_error_zeros: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.status != rar_pkg::ST_OK |->
      out_chan.result_num == '0 && out_chan.result_den == '0)
    else $error("error result carries nonzero fields");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && !out_chan.ready |=> out_chan.valid && $stable(out_chan.status))
    else $error("waiting result lost or changed");

endmodule

[tb/rational_arith_reduce_unit_tb.sv]
// Testbench for the rational arithmetic reduce unit: directed and random fraction transactions.
module rational_arith_reduce_unit_tb;

  localparam int OW        = rar_pkg::OPERAND_WIDTH_DEF;
  localparam int MAX_IDLE  = 18;
  localparam int TAIL_CYC  = 150;
  localparam int LIMIT_T   = 8_000_000;

  typedef struct packed {
    logic signed [rar_pkg::NUM_W-1:0] num;
    logic [rar_pkg::DEN_W-1:0]        den;
    rar_pkg::status_t                 st;
  } frac_t;

  logic clk;
  logic rst_n;
  bit   src_quiet;
  bit   sink_quiet;
  int   errors;
  int   stall_left;
  int   stall_draw;
  frac_t due;
  frac_t pending_fracs[$];

  rar_in_if #(.OPERAND_WIDTH(OW)) in_chan ();
  rar_out_if out_chan ();

  rational_arith_reduce_unit #(.OPERAND_WIDTH(OW)) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(LIMIT_T);
    $display("Regression FAIL");
    $finish;
  end

  function automatic int draw_wait(bit quiet);
    return quiet ? 0 : $urandom_range(0, MAX_IDLE);
  endfunction

  function automatic frac_t reduce_quotient(rar_pkg::op_t op, logic signed [OW-1:0] a,
                                            logic signed [OW-1:0] b,
                                            logic signed [OW-1:0] c,
                                            logic signed [OW-1:0] d);
    longint n;
    longint m;
    longint unsigned un;
    longint unsigned um;
    longint unsigned x;
    longint unsigned y;
    longint unsigned r;
    bit neg;
    frac_t f;
    f.num = '0;
    f.den = '0;
    f.st  = rar_pkg::ST_OK;
    if (b == 0 || d == 0) begin
      f.st = rar_pkg::ST_ZERO_DEN;
      return f;
    end
    if (op == rar_pkg::OP_DIV && c == 0) begin
      f.st = rar_pkg::ST_DIV_ZERO;
      return f;
    end
    case (op)
      rar_pkg::OP_ADD: begin
        n = longint'(a) * longint'(d) + longint'(b) * longint'(c);
        m = longint'(b) * longint'(d);
      end
      rar_pkg::OP_SUB: begin
        n = longint'(a) * longint'(d) - longint'(b) * longint'(c);
        m = longint'(b) * longint'(d);
      end
      rar_pkg::OP_MUL: begin
        n = longint'(a) * longint'(c);
        m = longint'(b) * longint'(d);
      end
      default: begin
        n = longint'(a) * longint'(d);
        m = longint'(b) * longint'(c);
      end
    endcase
    if (n == 0) begin
      f.den = rar_pkg::DEN_W'(1);
      return f;
    end
    neg = (n < 0) != (m < 0);
    un  = (n < 0) ? longint'(-n) : longint'(n);
    um  = (m < 0) ? longint'(-m) : longint'(m);
    x   = un;
    y   = um;
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    un = un / x;
    um = um / x;
    f.num = neg ? rar_pkg::NUM_W'(-longint'(un)) : rar_pkg::NUM_W'(un);
    f.den = rar_pkg::DEN_W'(um);
    return f;
  endfunction

  task automatic push_item(rar_pkg::op_t op, logic signed [OW-1:0] a,
                           logic signed [OW-1:0] b,
                           logic signed [OW-1:0] c, logic signed [OW-1:0] d);
    int gap;
    gap = draw_wait(src_quiet);
    if (gap != 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid    <= 1'b1;
    in_chan.req_type <= op;
    in_chan.num_a    <= a;
    in_chan.den_a    <= b;
    in_chan.num_b    <= c;
    in_chan.den_b    <= d;
    do @(posedge clk); while (!in_chan.ready);
    pending_fracs.push_back(reduce_quotient(op, a, b, c, d));
  endtask

  function automatic logic signed [OW-1:0] pick_operand(bit narrow);
    int v;
    int unsigned k;
    k = $urandom_range(0, 15);
    if (k == 0) begin
      case ($urandom_range(0, 4))
        0:       return {1'b1, {(OW-1){1'b0}}};
        1:       return {1'b0, {(OW-1){1'b1}}};
        2:       return '0;
        3:       return 1;
        default: return -1;
      endcase
    end
    if (narrow || k < 6) begin
      v = $urandom_range(0, 240);
      return OW'(v - 120);
    end
    return OW'($urandom);
  endfunction

  task automatic send_random(bit narrow);
    rar_pkg::op_t op;
    logic signed [OW-1:0] a;
    logic signed [OW-1:0] b;
    logic signed [OW-1:0] c;
    logic signed [OW-1:0] d;
    op = rar_pkg::op_t'($urandom_range(0, 3));
    a  = pick_operand(narrow);
    b  = pick_operand(narrow);
    c  = pick_operand(narrow);
    d  = pick_operand(narrow);
    if ($urandom_range(0, 24) != 0) begin
      if (b == 0) b = 1;
      if (d == 0) d = -1;
    end else if ($urandom_range(0, 1) == 0) begin
      b = '0;
    end else begin
      d = '0;
    end
    if (op == rar_pkg::OP_DIV && c == 0 && $urandom_range(0, 3) != 0) c = 7;
    if (op == rar_pkg::OP_DIV && $urandom_range(0, 24) == 0) c = '0;
    push_item(op, a, b, c, d);
  endtask

  task automatic test_basic_ops();
    push_item(rar_pkg::OP_ADD, 1, 2, 1, 3);
    push_item(rar_pkg::OP_SUB, 3, 4, 5, 6);
    push_item(rar_pkg::OP_MUL, -6, 10, 5, -9);
    push_item(rar_pkg::OP_DIV, -3, 4, 6, -8);
    push_item(rar_pkg::OP_ADD, 32767, -1, -32768, 1);
    push_item(rar_pkg::OP_SUB, -32768, 32767, 32767, -32768);
  endtask

  task automatic test_operand_extremes();
    push_item(rar_pkg::OP_ADD, -32768, -32768, -32768, -32768);
    push_item(rar_pkg::OP_ADD, 32767, 1, 32767, 1);
    push_item(rar_pkg::OP_MUL, -32768, 1, -32768, 1);
    push_item(rar_pkg::OP_DIV, -32768, 1, 1, -32768);
    push_item(rar_pkg::OP_DIV, 1, -32768, -32768, 1);
    push_item(rar_pkg::OP_MUL, 1, 32767, 1, -32768);
    push_item(rar_pkg::OP_SUB, 32767, 32767, -32768, -32768);
    push_item(rar_pkg::OP_DIV, 32767, -32768, -1, 32767);
  endtask

  task automatic test_zero_and_error_cases();
    push_item(rar_pkg::OP_ADD, 5, 0, 3, 7);
    push_item(rar_pkg::OP_SUB, 5, 7, 3, 0);
    push_item(rar_pkg::OP_MUL, 0, 0, 0, 0);
    push_item(rar_pkg::OP_DIV, 4, 0, 0, 9);
    push_item(rar_pkg::OP_DIV, 4, 9, 0, 5);
    push_item(rar_pkg::OP_DIV, -32768, -1, 0, -32768);
    push_item(rar_pkg::OP_MUL, 0, 5, 3, 7);
    push_item(rar_pkg::OP_SUB, 1, 2, 1, 2);
    push_item(rar_pkg::OP_ADD, -7, 3, 7, 3);
    push_item(rar_pkg::OP_DIV, 0, -3, 5, 2);
  endtask

  task automatic test_random_operands(int count);
    repeat (count) send_random(1'b0);
  endtask

  task automatic test_small_reductions(int count);
    repeat (count) send_random(1'b1);
  endtask

  task automatic test_streaming(int count);
    src_quiet  = 1'b1;
    sink_quiet = 1'b1;
    repeat (count) send_random($urandom_range(0, 1));
    src_quiet  = 1'b0;
    sink_quiet = 1'b0;
  endtask

  task automatic check_field(string field, logic signed [63:0] exp_v,
                             logic signed [63:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      stall_left     <= 0;
    end else if (out_chan.ready) begin
      if (out_chan.valid) begin
        stall_draw = draw_wait(sink_quiet);
        if (stall_draw != 0) begin
          out_chan.ready <= 1'b0;
          stall_left     <= stall_draw;
        end
      end
    end else if (out_chan.valid) begin
      if (stall_left <= 1) begin
        out_chan.ready <= 1'b1;
      end else begin
        stall_left <= stall_left - 1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_fracs.size() == 0) begin
        $display("%0t: unexpected transaction, actual %0d/%0d status %0d", $time,
                 out_chan.result_num, out_chan.result_den, out_chan.status);
        errors++;
      end else begin
        due = pending_fracs.pop_front();
        check_field("result_num", due.num, out_chan.result_num);
        check_field("result_den", {1'b0, due.den}, {1'b0, out_chan.result_den});
        check_field("status", {1'b0, due.st}, {1'b0, out_chan.status});
      end
    end
  end

  initial begin
    rst_n            = 1'b0;
    errors           = 0;
    src_quiet        = 1'b0;
    sink_quiet       = 1'b0;
    in_chan.valid    = 1'b0;
    in_chan.req_type = '0;
    in_chan.num_a    = '0;
    in_chan.den_a    = '0;
    in_chan.num_b    = '0;
    in_chan.den_b    = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_basic_ops();
    test_operand_extremes();
    test_zero_and_error_cases();
    test_random_operands(500);
    test_small_reductions(500);
    test_streaming(300);
    in_chan.valid <= 1'b0;
    while (pending_fracs.size() != 0) @(posedge clk);
    repeat (TAIL_CYC) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
